// File: rtl/core/fzg_pkg.sv
// Package for the frame rate zone grid adjuster.
// Widths, register index codes and divider transfer types.
// No dependencies; used by fzg_div and frame_rate_zone_grid_adjuster.
package fzg_pkg;

   localparam int MAX_SIDE  = 16;
   localparam int SIDE_W    = 5;
   localparam int TOTAL_W   = 9;
   localparam int DUR_W     = 24;
   localparam int RATE_W    = 16;
   localparam int PROD_W    = DUR_W + RATE_W + 1;
   localparam int CSR_IDX_W = 4;
   localparam int DIV_CNT_W = $clog2(TOTAL_W + 1);

   localparam logic [PROD_W-1:0] RATE_SCALE = PROD_W'(256000000);
   localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_SIDE);

   localparam logic [CSR_IDX_W-1:0] REG_AUTO_ADJUST    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_MULTI_USER     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_RATE    = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_RATE_MARGIN    = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_MANUAL_COLUMNS = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_MANUAL_ROWS    = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] REG_MAX_COLUMNS    = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ROWS       = CSR_IDX_W'(7);

   typedef struct packed {
      logic               start;
      logic [TOTAL_W-1:0] dividend;
      logic [SIDE_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [TOTAL_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: rtl/core/fzg_div.sv
// Restoring divider, one quotient bit per cycle, for the column rebalance.
// Depends on fzg_pkg for widths and the request and response types.
module fzg_div
   import fzg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SIDE_W-1:0]    rem_ff, rem_in;
   logic [TOTAL_W-1:0]   quo_ff, quo_in;
   logic [SIDE_W-1:0]    dvs_ff, dvs_in;

   logic [SIDE_W:0] rem_sh;
   logic [SIDE_W:0] rem_diff;
   logic            fits;

   assign rem_sh   = {rem_ff, quo_ff[TOTAL_W-1]};
   assign fits     = rem_sh >= {1'b0, dvs_ff};
   assign rem_diff = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(TOTAL_W);
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? rem_diff[SIDE_W-1:0] : rem_sh[SIDE_W-1:0];
         quo_in = {quo_ff[TOTAL_W-2:0], fits};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// File: rtl/core/frame_rate_zone_grid_adjuster.sv
// Frame rate zone grid adjuster: top level, sequencer around one shared multiplier.
// Depends on fzg_pkg and fzg_div.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_frame_duration
//   rsp      out        rsp_valid / rsp_ready  rsp_grid_columns, rsp_grid_rows,
//                                              rsp_grid_total, rsp_grid_changed
//   csr      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// Single viewer or manual mode: S_TOT, then S_OUT, which loads the result register.
// Automatic mode: S_MLO, S_MHI, S_STEP, then S_M1 to S_M4 when the grid changes and S_DIV
// when a rebalance runs the bit-serial divider, then S_TOT and S_OUT; the multiplier is a shared 24x17 one.
// One item at a time: req_ready is high only while the sequencer is idle.
// A result waiting on rsp_ready holds the sequencer in its last step.
// Reset is synchronous; csr_ready is always high.
module frame_rate_zone_grid_adjuster
   import fzg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [DUR_W-1:0]     req_frame_duration,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [SIDE_W-1:0]    rsp_grid_columns,
   output logic [SIDE_W-1:0]    rsp_grid_rows,
   output logic [TOTAL_W-1:0]   rsp_grid_total,
   output logic                 rsp_grid_changed,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [RATE_W-1:0]    csr_wdata
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MLO  = 4'd1;
   localparam logic [3:0] S_MHI  = 4'd2;
   localparam logic [3:0] S_STEP = 4'd3;
   localparam logic [3:0] S_M1   = 4'd4;
   localparam logic [3:0] S_M2   = 4'd5;
   localparam logic [3:0] S_M3   = 4'd6;
   localparam logic [3:0] S_M4   = 4'd7;
   localparam logic [3:0] S_DIV  = 4'd8;
   localparam logic [3:0] S_TOT  = 4'd9;
   localparam logic [3:0] S_OUT  = 4'd10;

   localparam int T_W = 2 * SIDE_W + 2;

   // configuration
   logic              auto_ff, auto_in;
   logic              multi_ff, multi_in;
   logic [RATE_W-1:0] target_ff, target_in;
   logic [RATE_W-1:0] margin_ff, margin_in;
   logic [SIDE_W-1:0] man_col_ff, man_col_in;
   logic [SIDE_W-1:0] man_row_ff, man_row_in;
   logic [SIDE_W-1:0] max_col_ff, max_col_in;
   logic [SIDE_W-1:0] max_row_ff, max_row_in;

   // sequencer and state
   logic [3:0]         state_ff, state_in;
   logic [DUR_W-1:0]   dur_ff, dur_in;
   logic [SIDE_W-1:0]  col_ff, col_in;
   logic [SIDE_W-1:0]  row_ff, row_in;
   logic [TOTAL_W-1:0] zone_ff, zone_in;
   logic               chg_ff, chg_in;
   logic               slow_ff, slow_in;
   logic               up_ff, up_in;
   logic               reb_ff, reb_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [T_W-1:0]     t1_ff, t1_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SIDE_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [SIDE_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [TOTAL_W-1:0] rsp_tot_ff, rsp_tot_in;
   logic               rsp_chg_ff, rsp_chg_in;

   // shared multiplier
   logic [DUR_W-1:0]    mul_a;
   logic [RATE_W:0]     mul_b;
   logic [PROD_W-1:0]   mul_p;

   logic [RATE_W-1:0]   rate_lo;
   logic [RATE_W:0]     rate_hi;
   logic [SIDE_W-1:0]   v5;
   logic [SIDE_W+1:0]   col_x2;
   logic [SIDE_W+1:0]   mc_x3;
   logic [T_W-1:0]      t1_x3;
   logic [T_W-1:0]      t2_x2;
   logic [SIDE_W-1:0]   col_sat;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   assign rate_lo = target_ff - margin_ff;
   assign rate_hi = {1'b0, target_ff} + {1'b0, margin_ff};
   assign mul_p   = {{(PROD_W-DUR_W){1'b0}}, mul_a} * {{(PROD_W-RATE_W-1){1'b0}}, mul_b};
   assign v5      = csr_wdata[SIDE_W-1:0];

   assign col_x2 = {1'b0, col_ff, 1'b0};
   assign mc_x3  = {1'b0, max_col_ff, 1'b0} + {2'b0, max_col_ff};
   assign t1_x3  = {t1_ff[T_W-2:0], 1'b0} + t1_ff;
   assign t2_x2  = {prod_ff[T_W-2:0], 1'b0};

   assign col_sat = (div_rsp.quotient > {{(TOTAL_W-SIDE_W){1'b0}}, max_col_ff})
                    ? max_col_ff : div_rsp.quotient[SIDE_W-1:0];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MLO: begin
            mul_a = dur_ff;
            mul_b = {1'b0, rate_lo};
         end
         S_MHI: begin
            mul_a = dur_ff;
            mul_b = rate_hi;
         end
         S_M1: begin
            mul_a = {{(DUR_W-SIDE_W){1'b0}}, col_ff};
            mul_b = {{(RATE_W+1-SIDE_W){1'b0}}, max_row_ff};
         end
         S_M2: begin
            mul_a = {{(DUR_W-SIDE_W){1'b0}}, max_col_ff};
            mul_b = {{(RATE_W+1-SIDE_W){1'b0}}, row_ff};
         end
         S_M3, S_TOT: begin
            mul_a = {{(DUR_W-SIDE_W){1'b0}}, col_ff};
            mul_b = {{(RATE_W+1-SIDE_W){1'b0}}, row_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // configuration writes
   always_comb begin
      auto_in    = auto_ff;
      multi_in   = multi_ff;
      target_in  = target_ff;
      margin_in  = margin_ff;
      man_col_in = man_col_ff;
      man_row_in = man_row_ff;
      max_col_in = max_col_ff;
      max_row_in = max_row_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_AUTO_ADJUST: auto_in = csr_wdata[0];
            REG_MULTI_USER:  multi_in = csr_wdata[0];
            REG_TARGET_RATE: target_in = csr_wdata;
            REG_RATE_MARGIN: margin_in = csr_wdata;
            REG_MANUAL_COLUMNS: begin
               if (v5 != '0 && v5 <= max_col_ff && (v5 == SIDE_W'(1) || multi_ff))
                  man_col_in = v5;
            end
            REG_MANUAL_ROWS: begin
               if (v5 != '0 && v5 <= max_row_ff && (v5 == SIDE_W'(1) || multi_ff))
                  man_row_in = v5;
            end
            REG_MAX_COLUMNS: begin
               if (v5 != '0 && v5 <= SIDE_MAX)
                  max_col_in = v5;
            end
            REG_MAX_ROWS: begin
               if (v5 != '0 && v5 <= SIDE_MAX)
                  max_row_in = v5;
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      dur_in       = dur_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      zone_in      = zone_ff;
      chg_in       = chg_ff;
      slow_in      = slow_ff;
      up_in        = up_ff;
      reb_in       = reb_ff;
      prod_in      = prod_ff;
      t1_in        = t1_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_tot_in   = rsp_tot_ff;
      rsp_chg_in   = rsp_chg_ff;
      div_req.start    = 1'b0;
      div_req.dividend = prod_ff[TOTAL_W-1:0];
      div_req.divisor  = up_ff ? row_ff + SIDE_W'(1) : row_ff - SIDE_W'(1);

      if (rsp_valid_ff && rsp_ready)
         rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dur_in = req_frame_duration;
               if (!multi_ff) begin
                  col_in   = SIDE_W'(1);
                  row_in   = SIDE_W'(1);
                  chg_in   = zone_ff != TOTAL_W'(1);
                  state_in = S_TOT;
               end else if (!auto_ff) begin
                  col_in   = man_col_ff;
                  row_in   = man_row_ff;
                  chg_in   = !(man_col_ff == col_ff && man_row_ff == row_ff);
                  state_in = S_TOT;
               end else begin
                  state_in = S_MLO;
               end
            end
         end
         S_MLO: begin
            prod_in  = mul_p;
            state_in = S_MHI;
         end
         S_MHI: begin
            slow_in  = (target_ff > margin_ff) && (prod_ff > RATE_SCALE);
            prod_in  = mul_p;
            state_in = S_STEP;
         end
         S_STEP: begin
            chg_in = 1'b1;
            if (slow_ff) begin
               if (col_ff > SIDE_W'(1))      col_in = col_ff - SIDE_W'(1);
               else if (row_ff > SIDE_W'(1)) row_in = row_ff - SIDE_W'(1);
               else                          chg_in = 1'b0;
            end else if (prod_ff < RATE_SCALE) begin
               if (col_ff < max_col_ff)      col_in = col_ff + SIDE_W'(1);
               else if (row_ff < max_row_ff) row_in = row_ff + SIDE_W'(1);
               else                          chg_in = 1'b0;
            end else begin
               chg_in = 1'b0;
            end
            state_in = chg_in ? S_M1 : S_TOT;
         end
         S_M1: begin
            prod_in  = mul_p;
            state_in = S_M2;
         end
         S_M2: begin
            t1_in    = prod_ff[T_W-1:0];
            prod_in  = mul_p;
            state_in = S_M3;
         end
         S_M3: begin
            // 2cr > 3mcr reduces to 2c > 3mc since r is at least one
            up_in    = (col_x2 > mc_x3) && (row_ff < max_row_ff);
            reb_in   = up_in || ((t1_x3 < t2_x2) && (row_ff > SIDE_W'(1)));
            prod_in  = mul_p;
            state_in = S_M4;
         end
         S_M4: begin
            if (reb_ff) begin
               div_req.start = 1'b1;
               state_in      = S_DIV;
            end else begin
               if (col_ff > max_col_ff)
                  col_in = max_col_ff;
               state_in = S_TOT;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               col_in   = col_sat;
               row_in   = up_ff ? row_ff + SIDE_W'(1) : row_ff - SIDE_W'(1);
               state_in = S_TOT;
            end
         end
         S_TOT: begin
            prod_in  = mul_p;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = col_ff;
               rsp_row_in   = row_ff;
               rsp_tot_in   = prod_ff[TOTAL_W-1:0];
               rsp_chg_in   = chg_ff;
               if (chg_ff)
                  zone_in = prod_ff[TOTAL_W-1:0];
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_ff      <= 1'b1;
         multi_ff     <= 1'b0;
         target_ff    <= RATE_W'(5120);
         margin_ff    <= RATE_W'(1024);
         man_col_ff   <= SIDE_W'(1);
         man_row_ff   <= SIDE_W'(1);
         max_col_ff   <= SIDE_MAX;
         max_row_ff   <= SIDE_W'(4);
         state_ff     <= S_IDLE;
         col_ff       <= SIDE_W'(1);
         row_ff       <= SIDE_W'(1);
         zone_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         auto_ff      <= auto_in;
         multi_ff     <= multi_in;
         target_ff    <= target_in;
         margin_ff    <= margin_in;
         man_col_ff   <= man_col_in;
         man_row_ff   <= man_row_in;
         max_col_ff   <= max_col_in;
         max_row_ff   <= max_row_in;
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         zone_ff      <= zone_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dur_ff     <= dur_in;
      chg_ff     <= chg_in;
      slow_ff    <= slow_in;
      up_ff      <= up_in;
      reb_ff     <= reb_in;
      prod_ff    <= prod_in;
      t1_ff      <= t1_in;
      rsp_col_ff <= rsp_col_in;
      rsp_row_ff <= rsp_row_in;
      rsp_tot_ff <= rsp_tot_in;
      rsp_chg_ff <= rsp_chg_in;
   end

   fzg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_ready        = state_ff == S_IDLE;
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_grid_columns = rsp_col_ff;
   assign rsp_grid_rows    = rsp_row_ff;
   assign rsp_grid_total   = rsp_tot_ff;
   assign rsp_grid_changed = rsp_chg_ff;

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff != '0 && col_ff <= SIDE_MAX)
      else $error("column count out of range");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff != '0 && row_ff <= SIDE_MAX)
      else $error("row count out of range");

   a_rsp_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_tot_ff == TOTAL_W'(rsp_col_ff) * TOTAL_W'(rsp_row_ff))
      else $error("reported total does not match grid");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == S_DIV)
      else $error("divider finished outside the rebalance step");

   a_quiet_csr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !req_valid) |=> state_ff == S_IDLE)
      else $error("sequencer left idle without a transfer");

endmodule

// File: bench/frame_rate_zone_grid_adjuster_tb.sv
// Testbench for frame_rate_zone_grid_adjuster: directed and random frame durations,
// register setups between phases, every result checked against an in-bench grid model.
// Depends on fzg_pkg and the frame_rate_zone_grid_adjuster RTL.
`timescale 1ns / 100ps

module frame_rate_zone_grid_adjuster_tb;
   import fzg_pkg::*;

   localparam longint unsigned FRAME_SCALE = 64'd256000000;
   localparam int unsigned DUR_MAX = 24'hFFFFFF;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_LAST = '1;
   localparam int RANDOM_PHASES = 22;
   localparam int PHASE_FRAMES = 25;
   localparam int STALL_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [SIDE_W-1:0]  columns;
      logic [SIDE_W-1:0]  rows;
      logic [TOTAL_W-1:0] total;
      logic               changed;
   } grid_report_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [DUR_W-1:0]     req_frame_duration = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [SIDE_W-1:0]    rsp_grid_columns;
   logic [SIDE_W-1:0]    rsp_grid_rows;
   logic [TOTAL_W-1:0]   rsp_grid_total;
   logic                 rsp_grid_changed;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [RATE_W-1:0]    csr_wdata = '0;

   // grid model: configuration and state
   bit          auto_on, multi_on;
   int unsigned target, margin, man_cols, man_rows, max_cols, max_rows;
   int unsigned cur_cols, cur_rows, zone_sum;

   grid_report_type pending_reports[$];
   bit           no_idle = 1'b0;
   int           mismatches = 0;
   int           frames_sent = 0;
   int           writes_done = 0;
   int           grid_changes = 0;
   int           quiet_cycles = 0;

   frame_rate_zone_grid_adjuster u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_frame_duration (req_frame_duration),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_grid_columns   (rsp_grid_columns),
      .rsp_grid_rows      (rsp_grid_rows),
      .rsp_grid_total     (rsp_grid_total),
      .rsp_grid_changed   (rsp_grid_changed),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void model_reset();
      auto_on  = 1'b1;
      multi_on = 1'b0;
      target   = 5120;
      margin   = 1024;
      man_cols = 1;
      man_rows = 1;
      max_cols = 16;
      max_rows = 4;
      cur_cols = 1;
      cur_rows = 1;
      zone_sum = 0;
   endfunction

   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [RATE_W-1:0] val);
      int unsigned v5;
      v5 = val[4:0];
      case (idx)
         REG_AUTO_ADJUST: auto_on = val[0];
         REG_MULTI_USER:  multi_on = val[0];
         REG_TARGET_RATE: target = val;
         REG_RATE_MARGIN: margin = val;
         REG_MANUAL_COLUMNS: begin
            if (v5 >= 1 && v5 <= max_cols && (v5 == 1 || multi_on)) man_cols = v5;
         end
         REG_MANUAL_ROWS: begin
            if (v5 >= 1 && v5 <= max_rows && (v5 == 1 || multi_on)) man_rows = v5;
         end
         REG_MAX_COLUMNS: begin
            if (v5 >= 1 && v5 <= MAX_SIDE) max_cols = v5;
         end
         REG_MAX_ROWS: begin
            if (v5 >= 1 && v5 <= MAX_SIDE) max_rows = v5;
         end
         default: ;
      endcase
   endfunction

   function automatic grid_report_type grid_step(input logic [DUR_W-1:0] dur);
      longint unsigned d;
      int unsigned     c, r;
      bit              changed, slow;
      grid_report_type rep;
      d = dur;
      if (!multi_on) begin
         cur_cols = 1;
         cur_rows = 1;
         changed  = (zone_sum != 1);
      end else if (!auto_on) begin
         changed  = !(man_cols == cur_cols && man_rows == cur_rows);
         cur_cols = man_cols;
         cur_rows = man_rows;
      end else begin
         c = cur_cols;
         r = cur_rows;
         changed = 1'b1;
         slow = 1'b0;
         if (target > margin) slow = (d * (target - margin)) > FRAME_SCALE;
         if (slow) begin
            if (c > 1) c--;
            else if (r > 1) r--;
            else changed = 1'b0;
         end else if ((d * (target + margin)) < FRAME_SCALE) begin
            if (c < max_cols) c++;
            else if (r < max_rows) r++;
            else changed = 1'b0;
         end else begin
            changed = 1'b0;
         end
         if (changed) begin
            if (2 * c * r > 3 * max_cols * r && r < max_rows) begin
               c = (c * r) / (r + 1);
               r++;
            end else if (3 * c * max_rows < 2 * max_cols * r && r > 1) begin
               c = (c * r) / (r - 1);
               r--;
            end
            if (c > max_cols) c = max_cols;
         end
         cur_cols = c;
         cur_rows = r;
      end
      if (changed) zone_sum = (cur_cols * cur_rows) & 9'h1FF;
      rep.columns = cur_cols[SIDE_W-1:0];
      rep.rows    = cur_rows[SIDE_W-1:0];
      rep.total   = TOTAL_W'(cur_cols * cur_rows);
      rep.changed = changed;
      return rep;
   endfunction

   // valid stays high after the transfer; the next call moves or drops it
   task automatic send_frame(input logic [DUR_W-1:0] dur);
      int gap;
      grid_report_type rep;
      gap = 0;
      csr_valid <= 1'b0;
      if (!no_idle && $urandom_range(99) < 21) gap = $urandom_range(1, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_frame_duration <= dur;
      do @(posedge clock); while (!req_ready);
      rep = grid_step(dur);
      pending_reports.insert(pending_reports.size(), rep);
      frames_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, val);
      writes_done++;
   endtask

   task automatic check_field(input string field, input logic [TOTAL_W-1:0] want,
                              input logic [TOTAL_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : check_results
      grid_report_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_reports.size() == 0) begin
               $error("unexpected result: columns %0d rows %0d total %0d changed %0d",
                      rsp_grid_columns, rsp_grid_rows, rsp_grid_total, rsp_grid_changed);
               mismatches++;
            end else begin
               want = pending_reports.pop_front();
               check_field("grid_columns", want.columns, rsp_grid_columns);
               check_field("grid_rows", want.rows, rsp_grid_rows);
               check_field("grid_total", want.total, rsp_grid_total);
               check_field("grid_changed", want.changed, rsp_grid_changed);
               if (rsp_grid_changed === 1'b1) grid_changes++;
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else if (quiet_cycles >= STALL_LIMIT) begin
            $display("frame_rate_zone_grid_adjuster verification failed");
            $finish;
         end else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(99) >= 21);
   end

   task automatic test_single_viewer();
      send_frame('0);
      send_frame(DUR_MAX);
      send_frame(41666);
   endtask

   task automatic test_register_rules();
      write_reg(REG_MANUAL_COLUMNS, 3);
      write_reg(REG_MAX_COLUMNS, 0);
      write_reg(REG_MAX_ROWS, 17);
      write_reg(REG_AUTO_ADJUST, 16'hFFFE);
      write_reg(REG_MULTI_USER, 1);
      write_reg(REG_MANUAL_COLUMNS, 16'h0023);
      write_reg(REG_MANUAL_ROWS, 5);
      write_reg(CSR_IDX_W'(REG_MAX_ROWS + 1), 16'hFFFF);
      write_reg(REG_UNUSED_LAST, 16'h5A5A);
      send_frame(1000);
      send_frame(1000);
      write_reg(REG_MAX_ROWS, 16);
      write_reg(REG_MAX_COLUMNS, 16'hFFF0);
      write_reg(REG_MANUAL_ROWS, 16);
      write_reg(REG_MANUAL_COLUMNS, 16);
      write_reg(REG_MANUAL_COLUMNS, 0);
      send_frame(DUR_MAX);
      write_reg(REG_MULTI_USER, 0);
      send_frame(500);
      write_reg(REG_MULTI_USER, 16'h8001);
      send_frame(500);
   endtask

   // band edges for target 20 fps, margin 4 fps
   task automatic test_rate_band();
      write_reg(REG_AUTO_ADJUST, 1);
      send_frame(62501);
      send_frame(62500);
      send_frame(41667);
      send_frame(41666);
      send_frame('0);
      send_frame(DUR_MAX);
      write_reg(REG_TARGET_RATE, 1000);
      write_reg(REG_RATE_MARGIN, 1000);
      send_frame(DUR_MAX);
      write_reg(REG_TARGET_RATE, 16'hFFFF);
      write_reg(REG_RATE_MARGIN, 16'hFFFF);
      send_frame('0);
      write_reg(REG_TARGET_RATE, 0);
      write_reg(REG_RATE_MARGIN, 0);
      send_frame(12345);
   endtask

   task automatic test_shrunk_limits();
      write_reg(REG_AUTO_ADJUST, 0);
      write_reg(REG_MANUAL_COLUMNS, 16);
      write_reg(REG_MANUAL_ROWS, 2);
      send_frame(100);
      write_reg(REG_AUTO_ADJUST, 1);
      write_reg(REG_MAX_COLUMNS, 4);
      write_reg(REG_MAX_ROWS, 8);
      send_frame('0);
      write_reg(REG_TARGET_RATE, 5120);
      write_reg(REG_RATE_MARGIN, 1024);
      send_frame(DUR_MAX);
      write_reg(REG_MAX_ROWS, 2);
      write_reg(REG_MAX_COLUMNS, 1);
      send_frame(DUR_MAX);
      send_frame(1);
   endtask

   function automatic logic [RATE_W-1:0] pick_side();
      logic [RATE_W-1:0] v;
      case ($urandom_range(9))
         0:       v = 1;
         1:       v = 16;
         2:       v = ($urandom_range(1) == 0) ? 0 : $urandom_range(17, 31);
         default: v = $urandom_range(1, 16);
      endcase
      if ($urandom_range(3) == 0) v = v | RATE_W'($urandom_range(1, 2047) << 5);
      return v;
   endfunction

   function automatic logic [DUR_W-1:0] pick_duration(input int fast_pct);
      int unsigned lo, hi, fast_lim, slow_min, sel;
      lo = (target > margin) ? target - margin : 0;
      hi = target + margin;
      fast_lim = (hi == 0) ? DUR_MAX : FRAME_SCALE / hi;
      slow_min = (lo == 0) ? DUR_MAX : FRAME_SCALE / lo + 1;
      if (fast_lim > DUR_MAX) fast_lim = DUR_MAX;
      if (slow_min > DUR_MAX) slow_min = DUR_MAX;
      sel = $urandom_range(99);
      if (sel < 3) return '0;
      if (sel < 6) return DUR_MAX;
      if (sel < 14) return DUR_W'($urandom);
      if (sel < 24) return $urandom_range(fast_lim, slow_min);
      if (sel < 24 + fast_pct) return $urandom_range(0, fast_lim);
      return $urandom_range(slow_min, (2 * slow_min > DUR_MAX) ? DUR_MAX : 2 * slow_min);
   endfunction

   task automatic randomize_setup();
      logic [RATE_W-1:0] tgt, mrg;
      bit                max_first, multi_first;
      max_first   = $urandom_range(1);
      multi_first = $urandom_range(1);
      case ($urandom_range(9))
         0:       tgt = 0;
         1:       tgt = 16'hFFFF;
         default: tgt = $urandom_range(2000, 12000);
      endcase
      case ($urandom_range(9))
         0:       mrg = 0;
         1:       mrg = 16'hFFFF;
         2:       mrg = RATE_W'($urandom);
         default: mrg = $urandom_range(0, tgt / 3);
      endcase
      if (multi_first) write_reg(REG_MULTI_USER, ($urandom_range(99) < 85) ? 1 : 0);
      if (max_first) begin
         write_reg(REG_MAX_COLUMNS, pick_side());
         write_reg(REG_MAX_ROWS, pick_side());
      end
      write_reg(REG_MANUAL_COLUMNS, pick_side());
      write_reg(REG_MANUAL_ROWS, pick_side());
      if (!max_first) begin
         write_reg(REG_MAX_COLUMNS, pick_side());
         write_reg(REG_MAX_ROWS, pick_side());
      end
      if (!multi_first) write_reg(REG_MULTI_USER, ($urandom_range(99) < 85) ? 1 : 0);
      write_reg(REG_AUTO_ADJUST, ($urandom_range(99) < 80) ? 1 : 0);
      write_reg(REG_TARGET_RATE, tgt);
      write_reg(REG_RATE_MARGIN, mrg);
      if ($urandom_range(3) == 0)
         write_reg(CSR_IDX_W'($urandom_range(REG_MAX_ROWS + 1, REG_UNUSED_LAST)),
                   RATE_W'($urandom));
   endtask

   task automatic test_random_phases();
      int fast_pct;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         no_idle <= (phase >= 9 && phase < 12);
         randomize_setup();
         fast_pct = $urandom_range(25, 65);
         for (int k = 0; k < PHASE_FRAMES; k++) send_frame(pick_duration(fast_pct));
      end
   endtask

   initial begin
      model_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_single_viewer();
      test_register_rules();
      test_rate_band();
      test_shrunk_limits();
      test_random_phases();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      no_idle   <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d frames and %0d register writes over %0d random setups,",
               frames_sent, writes_done, RANDOM_PHASES);
      $display("single viewer, manual and automatic modes; %0d results changed the grid",
               grid_changes);
      if (mismatches == 0) begin
         $display("frame_rate_zone_grid_adjuster verification clean");
      end else begin
         $display("frame_rate_zone_grid_adjuster verification failed");
      end
      $finish;
   end

endmodule
